// ===== rtl/svm_pkg.sv =====
`default_nettype none
package svm_pkg;
    localparam int DefMaxVoices   = 16;
    localparam int DefNumSounds   = 64;
    localparam int DefSampleDepth = 65536;

    localparam int ActW  = 3;
    localparam int IdW   = 6;
    localparam int AddrW = 16;
    localparam int SmpW  = 16;
    localparam int BaseW = 16;
    localparam int LenW  = 17;
    localparam int StW   = 2;
    localparam int MixW  = 20;
    localparam int CntW  = 5;

    localparam logic [ActW-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ActW-1:0] ACT_DEFINE = 3'd1;
    localparam logic [ActW-1:0] ACT_PLAY   = 3'd2;
    localparam logic [ActW-1:0] ACT_STOP   = 3'd3;
    localparam logic [ActW-1:0] ACT_TICK   = 3'd4;
    localparam logic [ActW-1:0] ACT_CLEAR  = 3'd5;

    localparam logic [StW-1:0] ST_OK   = 2'd0;
    localparam logic [StW-1:0] ST_BAD  = 2'd1;
    localparam logic [StW-1:0] ST_FULL = 2'd2;

    localparam logic [LenW-1:0] LEN_LIMIT = 17'd65536;

    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [IdW-1:0]   sound_id;
        logic [AddrW-1:0] sample_address;
        logic [SmpW-1:0]  sample_value;
        logic [BaseW-1:0] sound_base;
        logic [LenW-1:0]  sound_length;
    } item_t;
endpackage
`default_nettype wire

// ===== rtl/svm_front.sv =====
`default_nettype none
module svm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire svm_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_pop,
    output svm_pkg::item_t     q_item
);
    import svm_pkg::*;

    // two-entry queue of accepted items, length saturated on entry
    item_t         mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    item_t         fixed;
    logic          push;

    always_comb
    begin
        fixed = in_item;
        if (in_item.sound_length > LEN_LIMIT)
        begin
            fixed.sound_length = LEN_LIMIT;
        end
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= fixed;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/svm_back.sv =====
`default_nettype none
module svm_back #(
    parameter int MAX_VOICES   = svm_pkg::DefMaxVoices,
    parameter int NUM_SOUNDS   = svm_pkg::DefNumSounds,
    parameter int SAMPLE_DEPTH = svm_pkg::DefSampleDepth
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire svm_pkg::item_t       q_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [svm_pkg::StW-1:0]   status,
    output logic signed [svm_pkg::MixW-1:0] mixed_sample,
    output logic                      sample_valid,
    output logic [svm_pkg::CntW-1:0]  active_voices
);
    import svm_pkg::*;

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int MW = $clog2(SAMPLE_DEPTH);
    localparam int AccW = MixW + 7;
    localparam logic signed [AccW-1:0] SumMax = AccW'(524287);
    localparam logic signed [AccW-1:0] SumMin = -AccW'(524288);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_CLR   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_FETCH = 3'd6;

    // memories
    logic [SmpW-1:0]  smp_mem [SAMPLE_DEPTH];
    logic [SmpW-1:0]  smp_rd_reg;
    logic [BaseW-1:0] base_mem [NUM_SOUNDS];
    logic [LenW-1:0]  len_mem [NUM_SOUNDS];
    logic [BaseW-1:0] base_rd_reg;
    logic [LenW-1:0]  len_rd_reg;
    logic [NUM_SOUNDS-1:0] snd_ok_reg;

    // voice table
    logic [MAX_VOICES-1:0] vv_reg;
    logic [SW-1:0]   vs_reg  [MAX_VOICES];
    logic [LenW-1:0] vp_reg  [MAX_VOICES];

    logic [2:0]       state_reg;
    item_t            it_reg;
    logic [VW-1:0]    vi_reg;
    logic signed [AccW-1:0] acc_reg;

    logic [StW-1:0]   st_reg;
    logic signed [MixW-1:0] mix_reg;
    logic             sv_reg;
    logic             ov_reg;

    logic             id_ok;
    logic             id_ok_it;
    logic             play_ok;
    logic             res_set;
    logic [SW-1:0]    id_s;
    logic [BaseW-1:0] eff_base;
    logic [LenW-1:0]  eff_len;
    logic [LenW-1:0]  cur_pos;
    logic [MW-1:0]    rd_addr;
    logic             last_voice;
    logic             free_found;
    logic [VW-1:0]    free_idx;
    logic [CntW-1:0]  vcount;

    assign id_ok = (32'(q_item.sound_id) < NUM_SOUNDS);
    assign id_ok_it = (32'(it_reg.sound_id) < NUM_SOUNDS);
    assign id_s  = SW'(q_item.sound_id);
    assign q_pop = (state_reg == S_IDLE) && q_valid && !(ov_reg && out_stall);
    assign eff_base = snd_ok_reg[vs_reg[vi_reg]] ? base_rd_reg : '0;
    assign eff_len  = snd_ok_reg[vs_reg[vi_reg]] ? len_rd_reg : '0;
    assign cur_pos  = vp_reg[vi_reg];
    assign rd_addr  = MW'({1'b0, eff_base} + cur_pos);
    assign last_voice = (32'(vi_reg) == MAX_VOICES - 1);
    assign play_ok = id_ok_it && snd_ok_reg[SW'(it_reg.sound_id)]
        && (len_rd_reg != '0) && free_found;

    // result is ready after a short action, a play lookup or the end of a tick
    assign res_set = (q_pop && q_item.action != ACT_PLAY && q_item.action != ACT_TICK)
        || (state_reg == S_LOOK) || (state_reg == S_CLR);

    // lowest free slot and live count
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        vcount     = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--)
        begin
            if (!vv_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VW'(i);
            end
        end
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            vcount = vcount + CntW'(vv_reg[i]);
        end
    end

    // sample memory port
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.action == ACT_WRITE
            && 32'(q_item.sample_address) < SAMPLE_DEPTH)
        begin
            smp_mem[MW'(q_item.sample_address)] <= q_item.sample_value;
        end
        smp_rd_reg <= smp_mem[rd_addr];
    end

    // sound table port
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.action == ACT_DEFINE && id_ok)
        begin
            base_mem[id_s] <= q_item.sound_base;
            len_mem[id_s]  <= q_item.sound_length;
        end
        base_rd_reg <= base_mem[(state_reg == S_IDLE) ? id_s : vs_reg[vi_reg]];
        len_rd_reg  <= len_mem[(state_reg == S_IDLE) ? id_s : vs_reg[vi_reg]];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            it_reg <= q_item;
        end
    end

    // voice payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK && it_reg.action == ACT_PLAY && play_ok)
        begin
            vs_reg[free_idx] <= SW'(it_reg.sound_id);
            vp_reg[free_idx] <= '0;
        end
        else if (state_reg == S_ADD && vv_reg[vi_reg] && cur_pos < eff_len)
        begin
            vp_reg[vi_reg] <= cur_pos + 1'b1;
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (res_set)
        begin
            ov_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vv_reg     <= '0;
            snd_ok_reg <= '0;
            vi_reg     <= '0;
            acc_reg    <= '0;
            st_reg     <= ST_OK;
            mix_reg    <= '0;
            sv_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        st_reg  <= ST_OK;
                        mix_reg <= '0;
                        sv_reg  <= 1'b0;
                        vi_reg  <= '0;
                        acc_reg <= '0;
                        priority case (q_item.action)
                            ACT_DEFINE:
                            begin
                                if (id_ok)
                                begin
                                    snd_ok_reg[id_s] <= 1'b1;
                                end
                                else
                                begin
                                    st_reg <= ST_BAD;
                                end
                            end
                            ACT_PLAY:
                            begin
                                state_reg <= S_LOOK;
                            end
                            ACT_STOP:
                            begin
                                vv_reg <= '0;
                            end
                            ACT_TICK:
                            begin
                                state_reg <= S_READ;
                            end
                            ACT_CLEAR:
                            begin
                                vv_reg     <= '0;
                                snd_ok_reg <= '0;
                                state_reg  <= S_OUT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_LOOK:
                begin
                    if (!id_ok_it || !snd_ok_reg[SW'(it_reg.sound_id)]
                        || len_rd_reg == '0)
                    begin
                        st_reg <= ST_BAD;
                    end
                    else if (!free_found)
                    begin
                        st_reg <= ST_FULL;
                    end
                    else
                    begin
                        vv_reg[free_idx] <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                // sound entry is registered, fetch the sample next
                S_READ:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (vv_reg[vi_reg])
                    begin
                        if (cur_pos < eff_len)
                        begin
                            acc_reg <= acc_reg
                                + AccW'($signed(smp_rd_reg));
                            if (cur_pos + 1'b1 >= eff_len)
                            begin
                                vv_reg[vi_reg] <= 1'b0;
                            end
                        end
                        else
                        begin
                            vv_reg[vi_reg] <= 1'b0;
                        end
                    end
                    if (last_voice)
                    begin
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        vi_reg    <= vi_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                // saturate the sum into the result
                S_CLR:
                begin
                    sv_reg <= 1'b1;
                    if (acc_reg > SumMax)
                    begin
                        mix_reg <= MixW'(SumMax);
                    end
                    else if (acc_reg < SumMin)
                    begin
                        mix_reg <= MixW'(SumMin);
                    end
                    else
                    begin
                        mix_reg <= MixW'(acc_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign mixed_sample  = mix_reg;
    assign sample_valid  = sv_reg;
    assign active_voices = vcount;
endmodule
`default_nettype wire

// ===== rtl/sample_voice_mixer.sv =====
`default_nettype none
// Sample voice mixer: plays up to MAX_VOICES sounds out of a sample memory.
// Input channel: in_valid/in_stall with action and its operands; a
// transaction is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall, one result per input transaction:
// status, mixed_sample, sample_valid and active_voices.
// A two-entry queue sits in front of the execution sequencer.
// Sequencing: write, define, stop and unused actions finish on acceptance;
// clear passes through S_OUT, play through S_LOOK and S_OUT, and a tick
// through S_READ, S_FETCH and S_ADD for every voice, then S_CLR and S_OUT,
// with one sound-table read and one sample-memory read per voice.
// Throughput: one write, define or stop per cycle while out_stall is low.
// Only one item is processed at a time; the next one leaves the queue once
// the sequencer is idle and the previous result is taken.
// Reset empties the queue, stops all voices and marks every sound empty;
// sample memory content is undefined until written.
// While out_stall is high the result holds and the sequencer waits before
// starting the next item; the input queue then fills and raises in_stall.
module sample_voice_mixer #(
    parameter int MAX_VOICES   = svm_pkg::DefMaxVoices,
    parameter int NUM_SOUNDS   = svm_pkg::DefNumSounds,
    parameter int SAMPLE_DEPTH = svm_pkg::DefSampleDepth
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [svm_pkg::ActW-1:0]     action,
    input  wire logic [svm_pkg::IdW-1:0]      sound_id,
    input  wire logic [svm_pkg::AddrW-1:0]    sample_address,
    input  wire logic signed [svm_pkg::SmpW-1:0] sample_value,
    input  wire logic [svm_pkg::BaseW-1:0]    sound_base,
    input  wire logic [svm_pkg::LenW-1:0]     sound_length,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [svm_pkg::StW-1:0]           status,
    output logic signed [svm_pkg::MixW-1:0]   mixed_sample,
    output logic                              sample_valid,
    output logic [svm_pkg::CntW-1:0]          active_voices
);
    import svm_pkg::*;

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign in_item = '{action, sound_id, sample_address, sample_value,
                       sound_base, sound_length};

    svm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    svm_back #(
        .MAX_VOICES  (MAX_VOICES),
        .NUM_SOUNDS  (NUM_SOUNDS),
        .SAMPLE_DEPTH(SAMPLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .mixed_sample (mixed_sample),
        .sample_valid (sample_valid),
        .active_voices(active_voices)
    );

    // checks
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_voices) <= MAX_VOICES)
        else $error("voice count exceeds table size");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_sv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_valid) |-> status == ST_OK)
        else $error("tick result with non-ok status");
endmodule
`default_nettype wire
